/* hdl/tmeh_pkg.sv */
// Package for the truncated multiplier error histogram.
// Command codes, fixed field widths, histogram constants and the divider control struct.
// No dependencies.
package tmeh_pkg;

  localparam int CMD_W   = 2;
  localparam int LEVEL_W = 4;
  localparam int BIN_W   = 7;
  localparam int QUO_W   = 7;    // error percent 0..100
  localparam int BINS    = 101;  // bins per level
  localparam int PCT     = 100;

  typedef enum logic [CMD_W-1:0] {
    CMD_MUL   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic load;  // take a new numerator and divisor
    logic step;  // one restoring quotient bit
  } div_ctrl_t;

endpackage

/* hdl/tmeh_div.sv */
// Bit-serial restoring divider: floor(diff * 100 / den), one quotient bit a cycle while step is set.
// Depends on tmeh_pkg. Quotient must fit in QUO_W bits (diff <= den).
module tmeh_div #(
  parameter int DEN_W = 16
) (
  input  logic                        clk_i,
  input  tmeh_pkg::div_ctrl_t         ctrl_i,
  input  logic [DEN_W-1:0]            diff_i,
  input  logic [DEN_W-1:0]            den_i,
  output logic [tmeh_pkg::QUO_W-1:0]  quo_o
);

  localparam int QW    = tmeh_pkg::QUO_W;
  localparam int REM_W = DEN_W + QW;
  localparam int DVS_W = DEN_W + QW - 1;

  logic [REM_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [QW-1:0]    quo_q, quo_d;
  logic             ge;

  assign ge = rem_q >= REM_W'(dvs_q);

  always_comb begin
    rem_d = rem_q;
    dvs_d = dvs_q;
    quo_d = quo_q;
    if (ctrl_i.load) begin
      rem_d = REM_W'(diff_i) * REM_W'(tmeh_pkg::PCT);
      dvs_d = DVS_W'(den_i) << (QW - 1);
      quo_d = '0;
    end else if (ctrl_i.step) begin
      if (ge) begin
        rem_d = rem_q - REM_W'(dvs_q);
      end
      quo_d = {quo_q[QW-2:0], ge};
      dvs_d = dvs_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule

/* hdl/truncated_multiplier_error_histogram_top.sv */
// Truncated multiplier error histogram, top level. Uses tmeh_pkg and tmeh_div; the histogram
// memory lives here. A checker is bound to this module from tmeh_checker.sv.
//
// One transaction at a time. A multiply (command 0) first forms the exact product by shift-add,
// then works through every level in turn (row add, numerator load, seven divider steps, memory
// read, memory write). A zero product skips the levels. A bin read sets the memory address and
// then takes the registered read data; command 3 goes straight to the result. A clear sweeps
// the OPERAND_WIDTH*101 entries one per cycle. The same sweep runs after reset, during which
// s_axis_tready stays low. Results wait in an output register, so a new transaction can be
// taken while the last result is still pending on the master side.
module truncated_multiplier_error_histogram_top #(
  parameter int OPERAND_WIDTH = 8,
  parameter int COUNT_WIDTH   = 17
) (
  input  logic clk_i,
  input  logic rst_ni,
  // s_axis_tdata: operand_a, operand_b, level_select[3:0], bin_select[6:0], zero pad
  input  logic [((2*OPERAND_WIDTH+tmeh_pkg::LEVEL_W+tmeh_pkg::BIN_W+7)/8)*8-1:0] s_axis_tdata,
  // s_axis_tuser: command[1:0]
  input  logic [tmeh_pkg::CMD_W-1:0] s_axis_tuser,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // m_axis_tdata: exact_product, approx_product, error_percent[6:0], bin_count, zero pad
  output logic [((4*OPERAND_WIDTH+tmeh_pkg::QUO_W+COUNT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // m_axis_tuser: error_valid
  output logic m_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready
);

  localparam int W        = OPERAND_WIDTH;
  localparam int CW       = COUNT_WIDTH;
  localparam int PROD_W   = 2 * W;
  localparam int QW       = tmeh_pkg::QUO_W;
  localparam int BW       = tmeh_pkg::BIN_W;
  localparam int LW       = tmeh_pkg::LEVEL_W;
  localparam int DEPTH    = W * tmeh_pkg::BINS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int LIDX_W   = $clog2(W);
  localparam int CNT_W    = $clog2(W + 8);
  localparam int OUT_W    = 2 * PROD_W + QW + CW;
  localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CLEAR = 11'b000_0000_0010,
    S_MUL   = 11'b000_0000_0100,
    S_LVL   = 11'b000_0000_1000,
    S_NUM   = 11'b000_0001_0000,
    S_DIV   = 11'b000_0010_0000,
    S_RD    = 11'b000_0100_0000,
    S_WR    = 11'b000_1000_0000,
    S_RB    = 11'b001_0000_0000,
    S_RBW   = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_e;

  state_e               state_q, state_d;
  tmeh_pkg::cmd_e       cmd_q, cmd_d;
  logic [W-1:0]         mpl_q, mpl_d;       // multiplier, LSB first for the exact product
  logic [W-1:0]         btop_q, btop_d;     // multiplier, MSB first for the truncated rows
  logic [PROD_W-1:0]    mcand_q, mcand_d;
  logic [PROD_W-1:0]    exact_q, exact_d;
  logic [PROD_W-1:0]    row_q, row_d;
  logic [PROD_W-1:0]    approx_q, approx_d;
  logic [PROD_W-1:0]    apsel_q, apsel_d;
  logic [QW-1:0]        errsel_q, errsel_d;
  logic [LIDX_W-1:0]    lidx_q, lidx_d;
  logic [LIDX_W-1:0]    lsel_q, lsel_d;
  logic [BW-1:0]        bin_q, bin_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [ADDR_W-1:0]    base_q, base_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic                 nz_q, nz_d;
  logic                 clr_resp_q, clr_resp_d;
  logic [CW-1:0]        count_q, count_d;
  logic                 m_valid_q, m_valid_d;
  logic [OUT_TD_W-1:0]  m_data_q, m_data_d;
  logic                 m_user_q, m_user_d;

  // histogram memory
  logic [CW-1:0]        mem_q [DEPTH];
  logic [CW-1:0]        rdata_q;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_addr;
  logic [CW-1:0]        mem_wdata;

  tmeh_pkg::div_ctrl_t  div_ctrl;
  logic [QW-1:0]        quo;

  // input field unpacking
  logic [W-1:0]         in_a, in_b;
  logic [LW-1:0]        in_lvl;
  logic [BW-1:0]        in_bin;
  logic                 in_acc;
  logic                 out_free;
  logic                 rec_valid;
  tmeh_pkg::cmd_e       in_cmd;

  assign in_a     = s_axis_tdata[W-1:0];
  assign in_b     = s_axis_tdata[2*W-1:W];
  assign in_lvl   = s_axis_tdata[2*W+LW-1:2*W];
  assign in_bin   = s_axis_tdata[2*W+LW+BW-1:2*W+LW];
  assign in_cmd   = tmeh_pkg::cmd_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign rec_valid     = (cmd_q == tmeh_pkg::CMD_MUL) && nz_q;

  tmeh_div #(
    .DEN_W (PROD_W)
  ) u_div (
    .clk_i  (clk_i),
    .ctrl_i (div_ctrl),
    .diff_i (exact_q - approx_q),
    .den_i  (exact_q),
    .quo_o  (quo)
  );

  // memory port: one address per cycle, read data registered
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    mem_addr  = addr_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_RD: begin
        mem_addr = base_q + ADDR_W'(quo);
      end
      S_WR: begin
        mem_we    = 1'b1;
        // saturating increment
        mem_wdata = (rdata_q == {CW{1'b1}}) ? rdata_q : rdata_q + CW'(1);
      end
      S_RB: begin
        mem_addr = ADDR_W'(lsel_q) * ADDR_W'(tmeh_pkg::BINS) + ADDR_W'(bin_q);
      end
      default: begin
        mem_addr = addr_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_addr];
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    mpl_d      = mpl_q;
    btop_d     = btop_q;
    mcand_d    = mcand_q;
    exact_d    = exact_q;
    row_d      = row_q;
    approx_d   = approx_q;
    apsel_d    = apsel_q;
    errsel_d   = errsel_q;
    lidx_d     = lidx_q;
    lsel_d     = lsel_q;
    bin_d      = bin_q;
    cnt_d      = cnt_q;
    base_d     = base_q;
    addr_d     = addr_q;
    nz_d       = nz_q;
    clr_resp_d = clr_resp_q;
    count_d    = count_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;
    div_ctrl   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d    = in_cmd;
          mpl_d    = in_b;
          btop_d   = in_b;
          mcand_d  = PROD_W'(in_a);
          row_d    = PROD_W'(in_a) << (W - 1);
          exact_d  = '0;
          approx_d = '0;
          lidx_d   = '0;
          base_d   = '0;
          cnt_d    = '0;
          bin_d    = in_bin;
          nz_d     = (in_a != '0) && (in_b != '0);
          // level 0 reads as 1, anything above the width as the width
          if (in_lvl == '0) begin
            lsel_d = '0;
          end else if (int'(in_lvl) > W) begin
            lsel_d = LIDX_W'(W - 1);
          end else begin
            lsel_d = LIDX_W'(in_lvl - LW'(1));
          end
          unique case (in_cmd)
            tmeh_pkg::CMD_MUL: begin
              state_d = S_MUL;
            end
            tmeh_pkg::CMD_READ: begin
              state_d = S_RB;
            end
            tmeh_pkg::CMD_CLEAR: begin
              addr_d     = '0;
              clr_resp_d = 1'b1;
              state_d    = S_CLEAR;
            end
            tmeh_pkg::CMD_NOP: begin
              state_d = S_OUT;
            end
            default: begin
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_CLEAR: begin
        addr_d = addr_q + ADDR_W'(1);
        if (addr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = clr_resp_q ? S_OUT : S_IDLE;
        end
      end
      S_MUL: begin
        if (mpl_q[0]) begin
          exact_d = exact_q + mcand_q;
        end
        mcand_d = mcand_q << 1;
        mpl_d   = mpl_q >> 1;
        cnt_d   = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(W - 1)) begin
          state_d = nz_q ? S_LVL : S_OUT;
        end
      end
      S_LVL: begin
        // next row down from the top of the multiplier
        if (btop_q[W-1]) begin
          approx_d = approx_q + row_q;
        end
        btop_d  = btop_q << 1;
        row_d   = row_q >> 1;
        state_d = S_NUM;
      end
      S_NUM: begin
        div_ctrl.load = 1'b1;
        cnt_d         = '0;
        state_d       = S_DIV;
      end
      S_DIV: begin
        div_ctrl.step = 1'b1;
        cnt_d         = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QW - 1)) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        addr_d = mem_addr;
        if (lidx_q == lsel_q) begin
          apsel_d  = approx_q;
          errsel_d = quo;
        end
        state_d = S_WR;
      end
      S_WR: begin
        base_d = base_q + ADDR_W'(tmeh_pkg::BINS);
        lidx_d = lidx_q + LIDX_W'(1);
        if (lidx_q == LIDX_W'(W - 1)) begin
          state_d = S_OUT;
        end else begin
          state_d = S_LVL;
        end
      end
      S_RB: begin
        state_d = S_RBW;
      end
      S_RBW: begin
        count_d = (int'(bin_q) < tmeh_pkg::BINS) ? rdata_q : '0;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_user_d  = rec_valid;
          m_data_d  = OUT_TD_W'({
            (cmd_q == tmeh_pkg::CMD_READ) ? count_q : CW'(0),
            rec_valid ? errsel_q : QW'(0),
            rec_valid ? apsel_q : PROD_W'(0),
            (cmd_q == tmeh_pkg::CMD_MUL) ? exact_q : PROD_W'(0)
          });
          clr_resp_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      addr_q     <= '0;
      clr_resp_q <= 1'b0;
      m_valid_q  <= 1'b0;
      cnt_q      <= '0;
      lidx_q     <= '0;
      base_q     <= '0;
    end else begin
      state_q    <= state_d;
      addr_q     <= addr_d;
      clr_resp_q <= clr_resp_d;
      m_valid_q  <= m_valid_d;
      cnt_q      <= cnt_d;
      lidx_q     <= lidx_d;
      base_q     <= base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    mpl_q    <= mpl_d;
    btop_q   <= btop_d;
    mcand_q  <= mcand_d;
    exact_q  <= exact_d;
    row_q    <= row_d;
    approx_q <= approx_d;
    apsel_q  <= apsel_d;
    errsel_q <= errsel_d;
    lsel_q   <= lsel_d;
    bin_q    <= bin_d;
    nz_q     <= nz_d;
    count_q  <= count_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

/* hdl/tmeh_checker.sv */
// Port-level checker for the truncated multiplier error histogram, bound to the top level.
// Depends on tmeh_pkg for field widths.
module tmeh_checker #(
  parameter int OPERAND_WIDTH = 8,
  parameter int COUNT_WIDTH   = 17
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_tvalid_i,
  input logic s_tready_i,
  input logic m_tvalid_i,
  input logic m_tready_i,
  input logic m_tuser_i,
  input logic [((4*OPERAND_WIDTH+tmeh_pkg::QUO_W+COUNT_WIDTH+7)/8)*8-1:0] m_tdata_i
);

  localparam int PW = 2 * OPERAND_WIDTH;
  localparam int QW = tmeh_pkg::QUO_W;

  logic [PW-1:0] exact, approx;
  logic [QW-1:0] err;

  assign exact  = m_tdata_i[PW-1:0];
  assign approx = m_tdata_i[2*PW-1:PW];
  assign err    = m_tdata_i[2*PW+QW-1:2*PW];

  // pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("result changed while stalled");

  // one transaction in flight: no back-to-back accepts
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("input accepted while busy");

  // a recorded pair has a nonzero product and a truncation never exceeds it
  a_rec_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tuser_i |-> (exact != '0) && (approx <= exact))
    else $error("recorded pair with bad products");

  a_rec_percent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tuser_i |-> int'(err) <= tmeh_pkg::PCT)
    else $error("error percent above 100");

  a_unrec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tuser_i |-> (approx == '0) && (err == '0))
    else $error("unrecorded result carries error fields");

endmodule

bind truncated_multiplier_error_histogram_top tmeh_checker #(
  .OPERAND_WIDTH (OPERAND_WIDTH),
  .COUNT_WIDTH   (COUNT_WIDTH)
) u_tmeh_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid),
  .s_tready_i (s_axis_tready),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tuser_i  (m_axis_tuser),
  .m_tdata_i  (m_axis_tdata)
);

/* sim/tb_truncated_multiplier_error_histogram_top.sv */
// Self-checking testbench for truncated_multiplier_error_histogram_top: directed then random
// transactions, with a scoreboard that predicts products, error percents and bin counts.
// Depends on tmeh_pkg and the top-level RTL only.
module tb_truncated_multiplier_error_histogram_top;

  localparam int OPW       = 8;
  localparam int CNT_W     = 17;
  localparam int LEVELS    = OPW;
  localparam int LVL_W     = tmeh_pkg::LEVEL_W;
  localparam int BN_W      = tmeh_pkg::BIN_W;
  localparam int PCT_W     = tmeh_pkg::QUO_W;
  localparam int S_W       = ((2*OPW+LVL_W+BN_W+7)/8)*8;
  localparam int M_W       = ((4*OPW+PCT_W+CNT_W+7)/8)*8;
  localparam int RAND_ITEMS = 1725;
  localparam int HOLD_CYCLES = 400;
  // clear sweep plus a long receiver hold-off, taken several times over
  localparam int STALL_LIMIT = 6000;

  typedef struct packed {
    logic [2*OPW-1:0] exact;
    logic [2*OPW-1:0] approx;
    logic [PCT_W-1:0] pct;
    logic             recorded;
    logic [CNT_W-1:0] count;
  } hist_result_t;

  // Predicts each result and checks it against the block's output, oldest first.
  class histogram_scoreboard;
    logic [CNT_W-1:0] counts [0:LEVELS-1][0:tmeh_pkg::BINS-1];
    hist_result_t     expected_q[$];
    int unsigned      mismatches;

    function new();
      clear_counts();
      mismatches = 0;
    endfunction

    function void clear_counts();
      foreach (counts[l, n]) counts[l][n] = '0;
    endfunction

    // product of a with only the top k bits of b kept
    function logic [2*OPW-1:0] kept_rows_product(logic [OPW-1:0] a, logic [OPW-1:0] b, int k);
      logic [OPW-1:0] keep;
      keep = {OPW{1'b1}} << (OPW - k);
      return a * (b & keep);
    endfunction

    function int unsigned percent_error(logic [OPW-1:0] a, logic [OPW-1:0] b, int k);
      int unsigned exact;
      int unsigned approx;
      exact  = a * b;
      approx = kept_rows_product(a, b, k);
      if (exact == 0) return 0;
      return ((exact - approx) * tmeh_pkg::PCT) / exact;
    endfunction

    function int clamp_level(logic [LVL_W-1:0] lvl);
      if (lvl == 0) return 1;
      if (lvl > LEVELS) return LEVELS;
      return int'(lvl);
    endfunction

    function void note_transaction(tmeh_pkg::cmd_e cmd, logic [OPW-1:0] a, logic [OPW-1:0] b,
                                   logic [LVL_W-1:0] lvl, logic [BN_W-1:0] bin);
      hist_result_t r;
      int           k;
      int unsigned  e;
      r = '0;
      k = clamp_level(lvl);
      case (cmd)
        tmeh_pkg::CMD_MUL: begin
          if (a * b != 0) begin
            for (int j = 1; j <= LEVELS; j++) begin
              e = percent_error(a, b, j);
              if (counts[j-1][e] != {CNT_W{1'b1}}) counts[j-1][e] = counts[j-1][e] + 1'b1;
            end
            r.exact    = a * b;
            r.approx   = kept_rows_product(a, b, k);
            r.pct      = PCT_W'(percent_error(a, b, k));
            r.recorded = 1'b1;
          end
        end
        tmeh_pkg::CMD_READ: begin
          if (bin < tmeh_pkg::BINS) r.count = counts[k-1][bin];
        end
        tmeh_pkg::CMD_CLEAR: clear_counts();
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [M_W-1:0] data, logic recorded);
      hist_result_t exp_r;
      hist_result_t got;
      got.exact    = data[2*OPW-1:0];
      got.approx   = data[4*OPW-1:2*OPW];
      got.pct      = data[4*OPW+PCT_W-1:4*OPW];
      got.count    = data[4*OPW+PCT_W+CNT_W-1:4*OPW+PCT_W];
      got.recorded = recorded;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: exact=%0d approx=%0d pct=%0d rec=%0b count=%0d",
                   got.exact, got.approx, got.pct, got.recorded, got.count);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.exact !== exp_r.exact || got.approx !== exp_r.approx || got.pct !== exp_r.pct ||
          got.recorded !== exp_r.recorded || got.count !== exp_r.count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp exact=%0d approx=%0d pct=%0d rec=%0b count=%0d",
                   exp_r.exact, exp_r.approx, exp_r.pct, exp_r.recorded, exp_r.count);
          $display("          got exact=%0d approx=%0d pct=%0d rec=%0b count=%0d",
                   got.exact, got.approx, got.pct, got.recorded, got.count);
        end
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic [S_W-1:0]             s_axis_tdata;
  logic [tmeh_pkg::CMD_W-1:0] s_axis_tuser;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [M_W-1:0]             m_axis_tdata;
  logic                       m_axis_tuser;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;

  histogram_scoreboard sb;
  bit          gaps_on;       // random idling on both sides
  bit          hold_off_req;  // receiver holds off for a long stretch
  int unsigned stall_cycles;
  logic [OPW-1:0] last_a;
  logic [OPW-1:0] last_b;

  truncated_multiplier_error_histogram_top #(
    .OPERAND_WIDTH(OPW),
    .COUNT_WIDTH  (CNT_W)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),   // operand_a, operand_b, level_select, bin_select, zero pad
    .s_axis_tuser (s_axis_tuser),   // command
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // exact, approx, error_percent, bin_count, zero pad
    .m_axis_tuser (m_axis_tuser),   // error_valid
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Monitor and watchdog: both handshakes are sampled at the edge, before the block's
  // own updates land, so the sampled values are the ones that qualified the transfer.
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready)
      sb.note_transaction(tmeh_pkg::cmd_e'(s_axis_tuser),
                          s_axis_tdata[OPW-1:0], s_axis_tdata[2*OPW-1:OPW],
                          s_axis_tdata[2*OPW+LVL_W-1:2*OPW],
                          s_axis_tdata[2*OPW+LVL_W+BN_W-1:2*OPW+LVL_W]);
    if (m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("** truncated_multiplier_error_histogram_top: FAILED **");
      $finish;
    end else
      stall_cycles <= stall_cycles + 1;
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else
        m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= 23);
    end
  end

  // One transaction on the slave side; random idle cycles ahead of it.
  task automatic send_item(tmeh_pkg::cmd_e cmd, logic [OPW-1:0] a, logic [OPW-1:0] b,
                           logic [LVL_W-1:0] lvl, logic [BN_W-1:0] bin);
    while (gaps_on && $urandom_range(0, 99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= S_W'({bin, lvl, b, a});
    if (cmd == tmeh_pkg::CMD_MUL) begin
      last_a = a;
      last_b = b;
    end
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering, let the monitor note the last accepted transaction, then wait for
  // every predicted result.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [OPW-1:0] pick_operand();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      2: return 8'd1;
      3: return 8'd128;
      default: return OPW'($urandom);
    endcase
  endfunction

  initial begin
    logic [OPW-1:0]   a;
    logic [OPW-1:0]   b;
    logic [LVL_W-1:0] lvl;
    logic [BN_W-1:0]  bin;
    int               sel;
    sb            = new();
    gaps_on       = 1'b0;
    hold_off_req  = 1'b0;
    stall_cycles  = 0;
    last_a        = 8'd1;
    last_b        = 8'd1;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = tmeh_pkg::CMD_NOP;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: operand extremes, zero product, level and bin clamping, every command.
    send_item(tmeh_pkg::CMD_MUL,   8'd255, 8'd255, 4'd8,  7'd0);
    send_item(tmeh_pkg::CMD_MUL,   8'd255, 8'd255, 4'd1,  7'd0);
    send_item(tmeh_pkg::CMD_MUL,   8'd0,   8'd200, 4'd3,  7'd0);   // zero product
    send_item(tmeh_pkg::CMD_MUL,   8'd200, 8'd0,   4'd3,  7'd0);
    send_item(tmeh_pkg::CMD_MUL,   8'd1,   8'd1,   4'd1,  7'd0);   // all rows dropped
    send_item(tmeh_pkg::CMD_MUL,   8'd1,   8'd128, 4'd1,  7'd0);
    send_item(tmeh_pkg::CMD_MUL,   8'd170, 8'd85,  4'd0,  7'd0);   // level 0 behaves as 1
    send_item(tmeh_pkg::CMD_MUL,   8'd85,  8'd170, 4'd15, 7'd0);   // level above range as 8
    send_item(tmeh_pkg::CMD_MUL,   8'd37,  8'd99,  4'd4,  7'd127);
    send_item(tmeh_pkg::CMD_READ,  8'd0,   8'd0,   4'd8,  7'd0);
    send_item(tmeh_pkg::CMD_READ,  8'd0,   8'd0,   4'd1,  7'd100);
    send_item(tmeh_pkg::CMD_READ,  8'd0,   8'd0,   4'd1,  7'd0);
    send_item(tmeh_pkg::CMD_READ,  8'd0,   8'd0,   4'd3,  7'd127); // bin beyond 100 reads zero
    send_item(tmeh_pkg::CMD_READ,  8'd0,   8'd0,   4'd3,  7'd101);
    send_item(tmeh_pkg::CMD_READ,  8'd0,   8'd0,   4'd0,  7'd0);
    send_item(tmeh_pkg::CMD_READ,  8'd0,   8'd0,   4'd12, 7'd0);
    send_item(tmeh_pkg::CMD_NOP,   8'd255, 8'd255, 4'd15, 7'd127);
    send_item(tmeh_pkg::CMD_CLEAR, 8'd0,   8'd0,   4'd0,  7'd0);
    send_item(tmeh_pkg::CMD_READ,  8'd0,   8'd0,   4'd8,  7'd0);
    send_item(tmeh_pkg::CMD_MUL,   8'd255, 8'd1,   4'd8,  7'd0);
    send_item(tmeh_pkg::CMD_READ,  8'd0,   8'd0,   4'd8,  7'd0);

    // Random: mostly multiplies, some reads aimed at bins that were just hit, rare clears.
    gaps_on = 1'b1;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == 300) hold_off_req = 1'b1;           // receiver stalls, sender keeps offering
      if (i == 600) gaps_on = 1'b0;                // long stretch with no idling
      if (i == 900) gaps_on = 1'b1;
      if (i == 1100) wait_drained();               // sender pauses until all results are in
      sel = $urandom_range(0, 99);
      a   = pick_operand();
      b   = pick_operand();
      lvl = LVL_W'($urandom_range(1, LEVELS));
      if ($urandom_range(0, 9) == 0) lvl = LVL_W'($urandom);
      bin = BN_W'($urandom);
      if (sel < 68)
        send_item(tmeh_pkg::CMD_MUL, a, b, lvl, bin);
      else if (sel < 94) begin
        if ($urandom_range(0, 9) < 6) begin
          lvl = LVL_W'($urandom_range(1, LEVELS));
          bin = BN_W'(sb.percent_error(last_a, last_b, int'(lvl)));
        end else if ($urandom_range(0, 1) == 0)
          bin = BN_W'($urandom_range(0, tmeh_pkg::BINS - 1));
        send_item(tmeh_pkg::CMD_READ, a, b, lvl, bin);
      end else if (sel < 97)
        send_item(tmeh_pkg::CMD_NOP, a, b, lvl, bin);
      else
        send_item(tmeh_pkg::CMD_CLEAR, a, b, lvl, bin);
    end

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("** truncated_multiplier_error_histogram_top: PASSED **");
    else
      $display("** truncated_multiplier_error_histogram_top: FAILED **");
    $finish;
  end

endmodule

/* filelist.f */
hdl/tmeh_pkg.sv
hdl/tmeh_div.sv
hdl/truncated_multiplier_error_histogram_top.sv
hdl/tmeh_checker.sv
sim/tb_truncated_multiplier_error_histogram_top.sv
